// ===== hdl/mi_pkg.sv =====
// ----------------------------------------------------------------------------
// mi_pkg: shared types for the modular inverse block
// Transfer payloads and the operation codes of the shared step unit.
// ----------------------------------------------------------------------------
package mi_pkg;

    localparam int DATA_W = 64;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] modulus;
    } mi_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] inverse;
        logic              no_inverse;
    } mi_rsp_t;

    typedef enum logic [1:0] {
        UOP_HALVE,
        UOP_SUB,
        UOP_ADDM,
        UOP_SUBM
    } mi_op_t;

endpackage

// ===== hdl/mi_step_unit.sv =====
// ----------------------------------------------------------------------------
// mi_step_unit: shared step unit of the binary extended gcd
// One residue subtract or halve, with the matching update of its two signed
// Bezout coefficients, or a modulus add or subtract on the final coefficient.
// ----------------------------------------------------------------------------
module mi_step_unit
    import mi_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int CW    = 68
)
(
    input  mi_op_t                  op,
    input  logic [WIDTH-1:0]        p,
    input  logic [WIDTH-1:0]        o,
    input  logic [WIDTH-1:0]        x,
    input  logic [WIDTH-1:0]        y,
    input  logic signed [CW-1:0]    pc,
    input  logic signed [CW-1:0]    qc,
    input  logic signed [CW-1:0]    pco,
    input  logic signed [CW-1:0]    qco,
    output logic [WIDTH-1:0]        p_next,
    output logic signed [CW-1:0]    pc_next,
    output logic signed [CW-1:0]    qc_next
);

    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;
    logic signed [CW-1:0] pc_b;
    logic signed [CW-1:0] qc_b;
    logic signed [CW-1:0] pc_sum;
    logic signed [CW-1:0] qc_sum;
    logic                 pc_sub;
    logic                 qc_sub;
    logic                 odd;

    assign x_ext = $signed(CW'(x));
    assign y_ext = $signed(CW'(y));
    assign odd   = pc[0] | qc[0];

    always_comb
    begin
        pc_b   = '0;
        qc_b   = '0;
        pc_sub = 1'b0;
        qc_sub = 1'b0;
        case (op)
            UOP_HALVE:
            begin
                pc_b   = odd ? y_ext : '0;
                qc_b   = odd ? x_ext : '0;
                qc_sub = 1'b1;
            end
            UOP_SUB:
            begin
                pc_b   = pco;
                qc_b   = qco;
                pc_sub = 1'b1;
                qc_sub = 1'b1;
            end
            UOP_ADDM:
            begin
                qc_b = x_ext;
            end
            UOP_SUBM:
            begin
                qc_b   = x_ext;
                qc_sub = 1'b1;
            end
            default:
            begin
                pc_b = '0;
            end
        endcase
    end

    assign pc_sum = pc_sub ? (pc - pc_b) : (pc + pc_b);
    assign qc_sum = qc_sub ? (qc - qc_b) : (qc + qc_b);

    always_comb
    begin
        case (op)
            UOP_HALVE:
            begin
                p_next  = p >> 1;
                pc_next = pc_sum >>> 1;
                qc_next = qc_sum >>> 1;
            end
            UOP_SUB:
            begin
                p_next  = p - o;
                pc_next = pc_sum;
                qc_next = qc_sum;
            end
            default:
            begin
                p_next  = p;
                pc_next = pc;
                qc_next = qc_sum;
            end
        endcase
    end

endmodule

// ===== hdl/modular_inverse_top.sv =====
// ----------------------------------------------------------------------------
// Operation: one binary gcd step per cycle through the shared step unit,
//   then modulus corrections on the final coefficient until it lies in [0, m).
// Throughput: one item at a time; req_ready is high only while idle.
// Reset: rst_n clears the sequencer and the response valid at once.
// ----------------------------------------------------------------------------
// modular_inverse_top: modular inverse by binary extended gcd
// Sequencer around one shared step unit; result held until transferred.
// ----------------------------------------------------------------------------
module modular_inverse_top
    import mi_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  mi_req_t req,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output mi_rsp_t rsp
);

    localparam int CW = WIDTH + 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    mi_rsp_t rsp_reg, rsp_next;

    logic [WIDTH-1:0]     u_reg, u_next;
    logic [WIDTH-1:0]     v_reg, v_next;
    logic [WIDTH-1:0]     m_reg, m_next;
    logic [WIDTH-1:0]     y_reg, y_next;
    logic signed [CW-1:0] a_reg, a_next;
    logic signed [CW-1:0] b_reg, b_next;
    logic signed [CW-1:0] c_reg, c_next;
    logic signed [CW-1:0] d_reg, d_next;

    logic [WIDTH-1:0]     a_in;
    logic [WIDTH-1:0]     m_in;
    logic signed [CW-1:0] m_ext;

    mi_op_t               op;
    logic                 sel_v;
    logic                 wr_en;
    logic [WIDTH-1:0]     p_s;
    logic [WIDTH-1:0]     o_s;
    logic signed [CW-1:0] pc_s;
    logic signed [CW-1:0] qc_s;
    logic signed [CW-1:0] pco_s;
    logic signed [CW-1:0] qco_s;
    logic [WIDTH-1:0]     p_res;
    logic signed [CW-1:0] pc_res;
    logic signed [CW-1:0] qc_res;

    assign a_in  = req.value[WIDTH-1:0];
    assign m_in  = req.modulus[WIDTH-1:0];
    assign m_ext = $signed(CW'(m_reg));

    assign p_s   = sel_v ? v_reg : u_reg;
    assign o_s   = sel_v ? u_reg : v_reg;
    assign pc_s  = sel_v ? c_reg : a_reg;
    assign qc_s  = sel_v ? d_reg : b_reg;
    assign pco_s = sel_v ? a_reg : c_reg;
    assign qco_s = sel_v ? b_reg : d_reg;

    mi_step_unit #(
        .WIDTH (WIDTH),
        .CW    (CW)
    ) u_step (
        .op      (op),
        .p       (p_s),
        .o       (o_s),
        .x       (m_reg),
        .y       (y_reg),
        .pc      (pc_s),
        .qc      (qc_s),
        .pco     (pco_s),
        .qco     (qco_s),
        .p_next  (p_res),
        .pc_next (pc_res),
        .qc_next (qc_res)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        op         = UOP_HALVE;
        sel_v      = 1'b0;
        wr_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (m_in == WIDTH'(1))
                    begin
                        rsp_next   = '{inverse: '0, no_inverse: 1'b0};
                        state_next = ST_DONE;
                    end
                    else if ((m_in == '0) || (a_in == '0) || (!a_in[0] && !m_in[0]))
                    begin
                        rsp_next   = '{inverse: '0, no_inverse: 1'b1};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        u_next     = m_in;
                        v_next     = a_in;
                        m_next     = m_in;
                        y_next     = a_in;
                        a_next     = CW'(1);
                        b_next     = '0;
                        c_next     = '0;
                        d_next     = CW'(1);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (u_reg == '0)
                begin
                    if (v_reg == WIDTH'(1))
                    begin
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        rsp_next   = '{inverse: '0, no_inverse: 1'b1};
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                    if (!u_reg[0])
                    begin
                        op    = UOP_HALVE;
                        sel_v = 1'b0;
                    end
                    else if (!v_reg[0])
                    begin
                        op    = UOP_HALVE;
                        sel_v = 1'b1;
                    end
                    else
                    begin
                        op    = UOP_SUB;
                        sel_v = (u_reg < v_reg);
                    end
                end
            end
            ST_FIX:
            begin
                sel_v = 1'b1;
                if (d_reg[CW-1])
                begin
                    op    = UOP_ADDM;
                    wr_en = 1'b1;
                end
                else if (d_reg >= m_ext)
                begin
                    op    = UOP_SUBM;
                    wr_en = 1'b1;
                end
                else
                begin
                    rsp_next   = '{inverse: DATA_W'(d_reg[WIDTH-1:0]), no_inverse: 1'b0};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            if (sel_v)
            begin
                v_next = p_res;
                c_next = pc_res;
                d_next = qc_res;
            end
            else
            begin
                u_next = p_res;
                a_next = pc_res;
                b_next = qc_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        m_reg <= m_next;
        y_reg <= y_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

endmodule

// ===== hdl/mi_checker.sv =====
// ----------------------------------------------------------------------------
// mi_checker: port checks for the modular inverse block
// Watches the request and response transfers of the top level.
// ----------------------------------------------------------------------------
module mi_checker
    import mi_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    req_valid,
    input logic    req_ready,
    input mi_req_t req,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input mi_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a response is pending");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready stayed high after a request transfer");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.no_inverse |-> rsp.inverse == '0)
        else $error("nonzero inverse with no inverse flag");

endmodule

bind modular_inverse_top mi_checker u_mi_checker (.*);
